/* src/u8u16_pkg.sv */
package u8u16_pkg;

   localparam int COUNT_BITS = 16;
   localparam int QUEUE_DEPTH = 4;
   localparam int MAX_RESULTS = 3;

   localparam logic [15:0] REPL_UNIT = 16'h00D7;
   localparam logic [15:0] HI_SURR = 16'hD800;
   localparam logic [15:0] LO_SURR = 16'hDC00;
   localparam logic [30:0] PLANE1 = 31'h0001_0000;
   localparam logic [30:0] UNI_MAX = 31'h0010_FFFF;
   localparam logic [30:0] BMP_MAX = 31'h0000_FFFF;
   localparam logic [1:0] CONT_TAG = 2'b10;

   typedef logic [COUNT_BITS-1:0] count_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic end_of_string;
   } req_type;

   typedef struct packed {
      logic [7:0] first_byte;
      logic [7:0] second_byte;
      logic is_terminator;
      logic [15:0] char_count;
      logic last;
   } rsp_type;

   // one utf-16 unit waiting for the output side
   typedef struct packed {
      logic [15:0] unit;
      logic term;
      logic [15:0] count;
   } entry_type;

   // results of one decoded byte, in order, slot 0 first
   typedef struct packed {
      logic [1:0] num;
      entry_type [MAX_RESULTS-1:0] slot;
   } push_type;

   function automatic count_type sat_inc(count_type c);
      return (c == '1) ? c : count_type'(c + 1'b1);
   endfunction

   function automatic logic [15:0] sat16(count_type c);
      logic [31:0] wide;
      wide = 32'(c);
      return (wide > 32'h0000_FFFF) ? 16'hFFFF : wide[15:0];
   endfunction

endpackage

/* src/u8u16_decode.sv */
module u8u16_decode (
   input  logic clock,
   input  logic reset,
   input  logic fire,
   input  u8u16_pkg::req_type item,
   output u8u16_pkg::push_type push
);

   logic [30:0] accum_ff, accum_in;
   logic [2:0] tails_ff, tails_in;
   logic discarding_ff, discarding_in;
   u8u16_pkg::count_type chars_ff, chars_in;

   logic [7:0] b;
   logic eos;
   logic bad_cont, use_cont;
   logic [30:0] cont_accum;
   logic lead_have;
   logic [30:0] lead_val, lead_accum;
   logic [2:0] lead_tails;
   logic have;
   logic [30:0] val, accum_next, d;
   logic [2:0] tails_next;
   logic zero_term, tail_repl, term;
   logic [1:0] char_units;
   u8u16_pkg::count_type count_a, count_b, count_c, term_count;
   u8u16_pkg::entry_type cand [5];
   logic [4:0] cand_valid;
   logic [2:0] n;

   always_comb begin
      b = item.in_byte;
      eos = item.end_of_string;
      bad_cont = (tails_ff != 3'd0) && (b[7:6] != u8u16_pkg::CONT_TAG);
      use_cont = (tails_ff != 3'd0) && (b[7:6] == u8u16_pkg::CONT_TAG);
      cont_accum = {accum_ff[24:0], b[5:0]};

      lead_have = 1'b0;
      lead_val = 31'd0;
      lead_accum = 31'd0;
      lead_tails = 3'd0;
      priority if (b < 8'h80) begin
         lead_have = 1'b1;
         lead_val = 31'(b);
      end else if (b < 8'hC0 || b >= 8'hFE) begin
         lead_have = 1'b1;
         lead_val = 31'(u8u16_pkg::REPL_UNIT);
      end else if (b < 8'hE0) begin
         lead_accum = 31'(b[4:0]);
         lead_tails = 3'd1;
      end else if (b < 8'hF0) begin
         lead_accum = 31'(b[3:0]);
         lead_tails = 3'd2;
      end else if (b < 8'hF8) begin
         lead_accum = 31'(b[2:0]);
         lead_tails = 3'd3;
      end else if (b < 8'hFC) begin
         lead_accum = 31'(b[1:0]);
         lead_tails = 3'd4;
      end else begin
         lead_accum = 31'(b[0]);
         lead_tails = 3'd5;
      end

      if (use_cont) begin
         accum_next = cont_accum;
         tails_next = tails_ff - 3'd1;
         have = (tails_ff == 3'd1);
         val = cont_accum;
      end else begin
         accum_next = lead_accum;
         tails_next = lead_tails;
         have = lead_have;
         val = lead_val;
      end

      count_a = bad_cont ? u8u16_pkg::sat_inc(chars_ff) : chars_ff;
      zero_term = have && (val == 31'd0);
      priority if (val <= u8u16_pkg::BMP_MAX) char_units = 2'd1;
      else if (val <= u8u16_pkg::UNI_MAX) char_units = 2'd2;
      else char_units = 2'd0;
      count_b = (have && !zero_term) ? u8u16_pkg::sat_inc(count_a) : count_a;
      tail_repl = eos && !zero_term && (tails_next != 3'd0);
      count_c = tail_repl ? u8u16_pkg::sat_inc(count_b) : count_b;
      term = zero_term || eos;
      term_count = zero_term ? count_a : count_c;
      d = val - u8u16_pkg::PLANE1;

      // candidates in emission order
      cand[0] = '{unit: u8u16_pkg::REPL_UNIT, term: 1'b0, count: 16'h0};
      cand[1] = '{unit: (char_units == 2'd1) ? val[15:0]
                        : u8u16_pkg::HI_SURR + 16'(d[19:10]),
                  term: 1'b0, count: 16'h0};
      cand[2] = '{unit: u8u16_pkg::LO_SURR + 16'(d[9:0]), term: 1'b0, count: 16'h0};
      cand[3] = '{unit: u8u16_pkg::REPL_UNIT, term: 1'b0, count: 16'h0};
      cand[4] = '{unit: 16'h0000, term: 1'b1, count: u8u16_pkg::sat16(term_count)};
      cand_valid[0] = bad_cont;
      cand_valid[1] = have && !zero_term && (char_units != 2'd0);
      cand_valid[2] = have && !zero_term && (char_units == 2'd2);
      cand_valid[3] = tail_repl;
      cand_valid[4] = term;
      if (discarding_ff || !fire) cand_valid = 5'b0;

      push = '0;
      n = 3'd0;
      for (int i = 0; i < 5; i++) begin
         if (cand_valid[i]) begin
            if (n < 3'(u8u16_pkg::MAX_RESULTS)) push.slot[n[1:0]] = cand[i];
            n = n + 3'd1;
         end
      end
      push.num = n[1:0];

      accum_in = accum_ff;
      tails_in = tails_ff;
      chars_in = chars_ff;
      discarding_in = discarding_ff;
      if (fire) begin
         if (discarding_ff) begin
            discarding_in = !eos;
         end else if (term) begin
            accum_in = 31'd0;
            tails_in = 3'd0;
            chars_in = '0;
            discarding_in = zero_term && !eos;
         end else begin
            accum_in = accum_next;
            tails_in = tails_next;
            chars_in = count_b;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accum_ff <= 31'd0;
         tails_ff <= 3'd0;
         chars_ff <= '0;
         discarding_ff <= 1'b0;
      end else begin
         accum_ff <= accum_in;
         tails_ff <= tails_in;
         chars_ff <= chars_in;
         discarding_ff <= discarding_in;
      end
   end

   // a byte that ends the string always leaves a clean state
   a_eos_clears: assert property (@(posedge clock) disable iff (reset)
      fire && item.end_of_string |=> tails_ff == 3'd0 && !discarding_ff && chars_ff == '0)
      else $error("end of string left decode state behind");

   // a live byte marked end of string always sends a terminator
   a_eos_term: assert property (@(posedge clock) disable iff (reset)
      fire && item.end_of_string && !discarding_ff |-> push.num != 2'd0)
      else $error("end of string without terminator");

endmodule

/* src/u8u16_queue.sv */
module u8u16_queue (
   input  logic clock,
   input  logic reset,
   input  u8u16_pkg::push_type push,
   input  logic pop,
   output u8u16_pkg::entry_type head,
   output logic [2:0] count
);

   localparam int PTR_BITS = $clog2(u8u16_pkg::QUEUE_DEPTH);

   u8u16_pkg::entry_type mem_ff [u8u16_pkg::QUEUE_DEPTH];
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in, wr_ptr_ff, wr_ptr_in;
   logic [2:0] count_ff, count_in;

   always_comb begin
      rd_ptr_in = rd_ptr_ff + PTR_BITS'(pop);
      wr_ptr_in = wr_ptr_ff + PTR_BITS'(push.num);
      count_in = count_ff + 3'(push.num) - 3'(pop);
      head = mem_ff[rd_ptr_ff];
      count = count_ff;
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < u8u16_pkg::MAX_RESULTS; i++) begin
         if (2'(i) < push.num) mem_ff[wr_ptr_ff + PTR_BITS'(i)] <= push.slot[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff <= 3'd0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push.num != 2'd0 |-> 4'(count_ff) + 4'(push.num) - 4'(pop)
                           <= 4'(u8u16_pkg::QUEUE_DEPTH))
      else $error("result queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != 3'd0)
      else $error("result queue underflow");

endmodule

/* src/utf8_to_utf16_transcoder.sv */
// utf-8 bytes in, utf-16 units out, one byte accepted per cycle while the result queue has room
// path: an accepted byte is registered, decoded into the result queue while the queue holds
//   at most one unit, and rsp_valid rises once its first unit is in the queue
// throughput: 1 byte per cycle while each byte gives at most one unit and the output does
//   not stall; a 2- or 3-unit byte holds the input while the queue drains, one unit per cycle
// reset (synchronous, active high) clears decode state, count, queue and byte order
module utf8_to_utf16_transcoder (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  u8u16_pkg::req_type req_data,
   output logic rsp_valid,
   input  logic rsp_stall,
   output u8u16_pkg::rsp_type rsp_data,
   input  logic csr_write_enable,
   input  logic csr_write_data
);

   logic in_valid_ff, in_valid_in;
   u8u16_pkg::req_type in_item_ff;
   logic high_first_ff;
   logic fire, load, pop;
   u8u16_pkg::push_type push;
   u8u16_pkg::entry_type head;
   logic [2:0] queue_count;

   always_comb begin
      // room for a worst case byte of three units
      fire = in_valid_ff && (queue_count <= 3'd1);
      req_stall = in_valid_ff && !fire;
      load = req_valid && !req_stall;
      in_valid_in = load || (in_valid_ff && !fire);
      rsp_valid = (queue_count != 3'd0);
      pop = rsp_valid && !rsp_stall;
      rsp_data.first_byte = high_first_ff ? head.unit[15:8] : head.unit[7:0];
      rsp_data.second_byte = high_first_ff ? head.unit[7:0] : head.unit[15:8];
      rsp_data.is_terminator = head.term;
      rsp_data.char_count = head.count;
      rsp_data.last = head.term;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         high_first_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (csr_write_enable) high_first_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (load) in_item_ff <= req_data;
   end

   u8u16_decode u_decode (
      .clock(clock),
      .reset(reset),
      .fire(fire),
      .item(in_item_ff),
      .push(push)
   );

   u8u16_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .pop(pop),
      .head(head),
      .count(queue_count)
   );

   // a held byte is decoded once the queue drains
   a_held_word_moves: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && queue_count == 3'd0 |=> !in_valid_ff || $past(load))
      else $error("input word stuck with empty queue");

endmodule
